// ----- design/fpbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fpbc_pkg;

  // Fixed geometry of the block.
  localparam int PLANE_COUNT = 6;
  localparam int COORD_WIDTH = 16;
  localparam int AXIS_COUNT  = 3;
  localparam int COEF_COUNT  = 4;
  localparam int COEF_W      = 17;
  localparam int ENTRY_W     = 16;
  localparam int REG_COUNT   = 8;
  localparam int REG_W       = 32;
  localparam int REG_SEL_W   = $clog2(REG_COUNT);
  localparam int CFG_INDEX_W = 4;
  localparam int CLIP_W      = PLANE_COUNT;
  localparam int VIS_W       = 2;

  // Request operation codes.
  typedef enum logic {
    OP_POINT = 1'b0,
    OP_BOX   = 1'b1
  } opcode_t;

  // Box visibility codes.
  typedef enum logic [VIS_W-1:0] {
    VIS_OUTSIDE = 2'd0,
    VIS_PARTIAL = 2'd1,
    VIS_INSIDE  = 2'd2
  } vis_t;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic [REG_W-1:0]              cfg_reg_t;

  typedef struct packed {
    opcode_t opcode;
    coord_t  point_x;
    coord_t  point_y;
    coord_t  point_z;
    coord_t  box_min_x;
    coord_t  box_min_y;
    coord_t  box_min_z;
    coord_t  box_max_x;
    coord_t  box_max_y;
    coord_t  box_max_z;
  } req_t;

  typedef struct packed {
    logic [CLIP_W-1:0] clip_code;
    logic [VIS_W-1:0]  visibility;
  } rsp_t;

  // Matrix register reset values, identity in Q4.12.
  localparam cfg_reg_t REG_RESET [REG_COUNT] = '{
    32'h0000_1000, 32'h0000_0000, 32'h1000_0000, 32'h0000_0000,
    32'h0000_0000, 32'h0000_1000, 32'h0000_0000, 32'h1000_0000
  };

  // Column combined with column 3 for each plane, and whether it is added.
  localparam int   PLANE_COL [PLANE_COUNT] = '{2, 2, 0, 0, 1, 1};
  localparam logic PLANE_ADD [PLANE_COUNT] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  localparam int   W_COL = 3;

endpackage

`default_nettype wire

// ----- design/frustum_point_box_cull.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+------------------------------
// request   | start, busy, req                        | taken when start && !busy
// result    | done, result                            | one-cycle strobe, no stall
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | written when valid && ready and index < 8
//
// One request can be taken every cycle while rst is low; it passes through the request
// register and the result register around the plane dot products to its done strobe.
// Each of the six planes has its own near and far corner multipliers, so requests
// stream back to back. Reset is synchronous; busy is high only while rst is high.
// The result side cannot stall. cfg_ready is always high; a write rederives the
// planes in the same edge. Planes read as zero until the first register write.

module frustum_point_box_cull (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output      logic                            busy,
  input  wire fpbc_pkg::req_t                  req,
  output      logic                            done,
  output      fpbc_pkg::rsp_t                  result,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [fpbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fpbc_pkg::REG_W-1:0]      cfg_data
);
  import fpbc_pkg::*;

  localparam int PROD_W = COEF_W + COORD_WIDTH;
  localparam int DOT_W  = PROD_W + 2;

  // Sign-extend one 16-bit matrix half to coefficient width.
  function automatic coef_t half_of(input cfg_reg_t r, input logic hi);
    logic signed [ENTRY_W-1:0] h;
    h = hi ? r[REG_W-1:ENTRY_W] : r[ENTRY_W-1:0];
    return COEF_W'(h);
  endfunction

  cfg_reg_t regs      [REG_COUNT];
  cfg_reg_t regs_next [REG_COUNT];
  coef_t    coefs      [PLANE_COUNT][COEF_COUNT];
  coef_t    coefs_next [PLANE_COUNT][COEF_COUNT];
  logic     cfg_write;

  req_t     in_req;
  logic     in_valid;
  rsp_t     result_next;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready && (cfg_index < CFG_INDEX_W'(REG_COUNT));

  // Register file after the pending write.
  always_comb begin
    regs_next = regs;
    if (cfg_write) begin
      regs_next[cfg_index[REG_SEL_W-1:0]] = cfg_data;
    end
  end

  // Plane derivation: column 3 plus or minus another column, row by row.
  always_comb begin
    coef_t w_e;
    coef_t c_e;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int r = 0; r < COEF_COUNT; r++) begin
        w_e = half_of(regs_next[REG_SEL_W'(2 * W_COL + (r >> 1))], r[0]);
        c_e = half_of(regs_next[REG_SEL_W'(2 * PLANE_COL[p] + (r >> 1))], r[0]);
        coefs_next[p][r] = PLANE_ADD[p] ? (w_e + c_e) : (w_e - c_e);
      end
    end
  end

  // Matrix registers and derived planes.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs  <= REG_RESET;
      coefs <= '{default: '0};
    end else if (cfg_write) begin
      regs  <= regs_next;
      coefs <= coefs_next;
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_req <= req;
    end
  end

  // Per-plane tests: the near corner doubles as the point for point tests.
  always_comb begin
    coord_t mn [AXIS_COUNT];
    coord_t mx [AXIS_COUNT];
    coord_t pt [AXIS_COUNT];
    coord_t nv [AXIS_COUNT];
    coord_t fv [AXIS_COUNT];
    logic signed [PROD_W-1:0] np [AXIS_COUNT];
    logic signed [PROD_W-1:0] fp [AXIS_COUNT];
    logic signed [DOT_W-1:0]  d_term;
    logic signed [DOT_W-1:0]  dot_n;
    logic signed [DOT_W-1:0]  dot_f;
    logic [PLANE_COUNT-1:0]   near_le;
    logic [PLANE_COUNT-1:0]   near_neg;
    logic [PLANE_COUNT-1:0]   far_neg;
    mn = '{in_req.box_min_x, in_req.box_min_y, in_req.box_min_z};
    mx = '{in_req.box_max_x, in_req.box_max_y, in_req.box_max_z};
    pt = '{in_req.point_x, in_req.point_y, in_req.point_z};
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        if (in_req.opcode == OP_POINT) begin
          nv[a] = pt[a];
        end else begin
          nv[a] = coefs[p][a][COEF_W-1] ? mn[a] : mx[a];
        end
        fv[a] = coefs[p][a][COEF_W-1] ? mx[a] : mn[a];
        np[a] = coefs[p][a] * nv[a];
        fp[a] = coefs[p][a] * fv[a];
      end
      d_term = DOT_W'(coefs[p][COEF_COUNT-1]) <<< 4;
      dot_n  = DOT_W'(np[0]) + DOT_W'(np[1]) + DOT_W'(np[2]) + d_term;
      dot_f  = DOT_W'(fp[0]) + DOT_W'(fp[1]) + DOT_W'(fp[2]) + d_term;
      near_neg[p] = dot_n[DOT_W-1];
      near_le[p]  = dot_n[DOT_W-1] || (dot_n == '0);
      far_neg[p]  = dot_f[DOT_W-1];
    end

    if (in_req.opcode == OP_POINT) begin
      result_next.clip_code  = near_le;
      result_next.visibility = VIS_OUTSIDE;
    end else begin
      result_next.clip_code = '0;
      if (|near_neg) begin
        result_next.visibility = VIS_OUTSIDE;
      end else if (|far_neg) begin
        result_next.visibility = VIS_PARTIAL;
      end else begin
        result_next.visibility = VIS_INSIDE;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/fpbc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fpbc_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             start,
  input wire logic                             busy,
  input wire fpbc_pkg::req_t                   req,
  input wire logic                             done,
  input wire fpbc_pkg::rsp_t                   result,
  input wire logic                             cfg_valid,
  input wire logic                             cfg_ready,
  input wire logic [fpbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input wire logic [fpbc_pkg::REG_W-1:0]       cfg_data
);
  import fpbc_pkg::*;

  // Every taken request produces a result after the request and result registers.
  a_req_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("request taken without a result two cycles later");

  // No result appears without a matching earlier request.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result strobe without a matching request");

  // A point request reports no visibility.
  a_point_vis: assert property (@(posedge clk) disable iff (rst)
    (done && $past(req.opcode, 2) == OP_POINT) |-> (result.visibility == VIS_OUTSIDE))
    else $error("point result carries a visibility code");

  // A box request reports no clip code and a legal visibility.
  a_box_fields: assert property (@(posedge clk) disable iff (rst)
    (done && $past(req.opcode, 2) == OP_BOX) |->
      (result.clip_code == '0 && result.visibility != 2'd3))
    else $error("box result fields are inconsistent");

endmodule

bind frustum_point_box_cull fpbc_checker u_fpbc_checker (.*);

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import fpbc_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS  = 45;
  localparam int SETTLE_CYCLES = 8;

  // Matrix register map: column c, rows 2k and 2k+1 sit at index 2c+k.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COL0_ROWS01,
    REG_COL0_ROWS23,
    REG_COL1_ROWS01,
    REG_COL1_ROWS23,
    REG_COL2_ROWS01,
    REG_COL2_ROWS23,
    REG_COL3_ROWS01,
    REG_COL3_ROWS23
  } mat_reg_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  req_t                   req;
  logic                   done;
  rsp_t                   result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [REG_W-1:0]       cfg_data;

  frustum_point_box_cull dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the matrix and of the planes derived from it.
  cfg_reg_t              mat_regs    [REG_COUNT];
  cfg_reg_t              next_matrix [REG_COUNT];
  int                    plane_coef  [PLANE_COUNT][COEF_COUNT];
  logic [AXIS_COUNT-1:0] plane_neg   [PLANE_COUNT];

  rsp_t pending_results[$];

  int  mismatches;
  int  cycle_count;
  int  point_count;
  int  box_count;
  int  vis_seen [3];
  int  cfg_writes;
  int  settings_loaded;
  int  burst_left;
  bit  steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
             pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Signed 16-bit matrix entry at a column and row of the shadow registers.
  function automatic int mat_entry(int col, int row);
    cfg_reg_t          word;
    logic signed [15:0] half;
    word = mat_regs[2 * col + row / 2];
    half = (row % 2 == 1) ? word[31:16] : word[15:0];
    return int'(half);
  endfunction

  // Near and far combine column 2, left and right column 0, top and bottom
  // column 1; each plane adds or subtracts that column from column 3.
  function automatic void rebuild_planes();
    int col;
    bit add;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      col = (p < 2) ? 2 : (p < 4) ? 0 : 1;
      add = (p == 1) || (p == 3) || (p == 4);
      for (int r = 0; r < COEF_COUNT; r++) begin
        plane_coef[p][r] = add ? mat_entry(3, r) + mat_entry(col, r)
                               : mat_entry(3, r) - mat_entry(col, r);
      end
      for (int a = 0; a < AXIS_COUNT; a++) plane_neg[p][a] = plane_coef[p][a] < 0;
    end
  endfunction

  function automatic void apply_matrix_write(logic [CFG_INDEX_W-1:0] idx, cfg_reg_t data);
    if (idx < REG_COUNT) begin
      mat_regs[idx[REG_SEL_W-1:0]] = data;
      rebuild_planes();
    end
  endfunction

  // Plane dot product in Q.16; d is scaled from Q.12 by 16.
  function automatic longint face_dot(int p, longint x, longint y, longint z);
    return longint'(plane_coef[p][0]) * x + longint'(plane_coef[p][1]) * y +
           longint'(plane_coef[p][2]) * z + longint'(plane_coef[p][3]) * 16;
  endfunction

  function automatic rsp_t predict_cull(req_t r);
    rsp_t   o;
    longint lo [AXIS_COUNT];
    longint hi [AXIS_COUNT];
    longint nr [AXIS_COUNT];
    longint fr [AXIS_COUNT];
    bit     outside;
    bit     partial;
    o = '0;
    outside = 1'b0;
    partial = 1'b0;
    if (r.opcode == OP_POINT) begin
      for (int p = 0; p < PLANE_COUNT; p++)
        if (face_dot(p, r.point_x, r.point_y, r.point_z) <= 0) o.clip_code[p] = 1'b1;
    end else begin
      lo[0] = r.box_min_x;
      lo[1] = r.box_min_y;
      lo[2] = r.box_min_z;
      hi[0] = r.box_max_x;
      hi[1] = r.box_max_y;
      hi[2] = r.box_max_z;
      // The scan stops at the first plane that has the whole box behind it.
      for (int p = 0; p < PLANE_COUNT && !outside; p++) begin
        for (int a = 0; a < AXIS_COUNT; a++) begin
          nr[a] = plane_neg[p][a] ? lo[a] : hi[a];
          fr[a] = plane_neg[p][a] ? hi[a] : lo[a];
        end
        if (face_dot(p, nr[0], nr[1], nr[2]) < 0) outside = 1'b1;
        else if (face_dot(p, fr[0], fr[1], fr[2]) < 0) partial = 1'b1;
      end
      o.visibility = outside ? VIS_OUTSIDE : (partial ? VIS_PARTIAL : VIS_INSIDE);
    end
    return o;
  endfunction

  // Request with every bit random, including the fields the test ignores.
  function automatic req_t noise_request();
    logic [159:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(req_t)-1:0];
  endfunction

  function automatic req_t point_req(int x, int y, int z);
    req_t r;
    r = noise_request();
    r.opcode = OP_POINT;
    r.point_x = coord_t'(x);
    r.point_y = coord_t'(y);
    r.point_z = coord_t'(z);
    return r;
  endfunction

  function automatic req_t box_req(int x0, int y0, int z0, int x1, int y1, int z1);
    req_t r;
    r = noise_request();
    r.opcode = OP_BOX;
    r.box_min_x = coord_t'(x0);
    r.box_min_y = coord_t'(y0);
    r.box_min_z = coord_t'(z0);
    r.box_max_x = coord_t'(x1);
    r.box_max_y = coord_t'(y1);
    r.box_max_z = coord_t'(z1);
    return r;
  endfunction

  function automatic int near_coord(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly points and well-formed boxes around the origin, some of them
  // inverted on one axis, and a share of requests with every bit random.
  function automatic req_t random_request(int span);
    req_t r;
    int   lo [AXIS_COUNT];
    int   hi [AXIS_COUNT];
    int   ctr;
    int   half;
    int   flip;
    r = noise_request();
    if ($urandom_range(0, 6) != 0) begin
      if (r.opcode == OP_POINT) begin
        r = point_req(near_coord(span), near_coord(span), near_coord(span));
      end else begin
        for (int a = 0; a < AXIS_COUNT; a++) begin
          ctr = near_coord(span);
          half = $urandom_range(0, span / 2);
          lo[a] = ctr - half;
          hi[a] = ctr + half;
        end
        if ($urandom_range(0, 9) == 0) begin
          flip = $urandom_range(0, AXIS_COUNT - 1);
          ctr = lo[flip];
          lo[flip] = hi[flip];
          hi[flip] = ctr;
        end
        r = box_req(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
      end
    end
    return r;
  endfunction

  function automatic void set_entry(int col, int row, int val);
    logic [15:0] half;
    half = val[15:0];
    if (row % 2 == 1) next_matrix[2 * col + row / 2][31:16] = half;
    else next_matrix[2 * col + row / 2][15:0] = half;
  endfunction

  // Either raw random bits or a frustum-like matrix with noise off the
  // diagonal, sometimes with a perspective term taking w from -z.
  function automatic void pick_random_matrix();
    if ($urandom_range(0, 2) == 0) begin
      foreach (next_matrix[i]) next_matrix[i] = $urandom;
    end else begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) set_entry(c, r, int'($urandom_range(0, 1024)) - 512);
      set_entry(0, 0, $urandom_range(1024, 8192));
      set_entry(1, 1, $urandom_range(1024, 8192));
      set_entry(2, 2, ($urandom_range(0, 1) == 1) ? int'($urandom_range(1024, 8192))
                                                   : -int'($urandom_range(1024, 8192)));
      set_entry(3, 3, $urandom_range(4096, 32767));
      if ($urandom_range(0, 1) == 1) set_entry(2, 3, -4096);
    end
  endfunction

  // Bursts of requests with random gaps; junk is driven while start is low.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        req <= noise_request();
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Present one request at a falling edge and hold it until it is taken.
  task automatic send_req(input req_t r);
    rsp_t want;
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = predict_cull(r);
    pending_results.push_back(want);
    if (r.opcode == OP_POINT) point_count++;
    else begin
      box_count++;
      vis_seen[want.visibility]++;
    end
    @(negedge clk);
    pace_sender();
  endtask

  // Stop sending and wait until every expected result has arrived.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic write_matrix_reg(input logic [CFG_INDEX_W-1:0] idx, input cfg_reg_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_matrix_write(idx, data);
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic load_matrix();
    drain_results();
    for (int i = 0; i < REG_COUNT; i++) write_matrix_reg(CFG_INDEX_W'(i), next_matrix[i]);
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  // Results arrive as one-cycle strobes and are matched in order.
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result with no request outstanding: clip_code %h visibility %0d",
                   result.clip_code, result.visibility);
      end else begin
        want = pending_results.pop_front();
        if (result.clip_code !== want.clip_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("clip_code mismatch: expected %h, got %h",
                     want.clip_code, result.clip_code);
        end
        if (result.visibility !== want.visibility) begin
          mismatches++;
          if (mismatches <= 10)
            $display("visibility mismatch: expected %0d, got %0d",
                     want.visibility, result.visibility);
        end
      end
    end
  end

  // Planes stay zero until an in-range write, so writes past the last
  // register must leave every point clipped and every box inside.
  task automatic test_unloaded_planes();
    for (int i = REG_COUNT; i < (1 << CFG_INDEX_W); i++)
      write_matrix_reg(CFG_INDEX_W'(i), $urandom);
    cfg_valid <= 1'b0;
    send_req(point_req(0, 0, 0));
    send_req(point_req(32767, -32768, 32767));
    send_req(box_req(-16, -16, -16, 16, 16, 16));
    send_req(box_req(-32768, -32768, -32768, 32767, 32767, 32767));
    send_req(random_request(4000));
  endtask

  // Identity matrix: the frustum is the cube of half size 1.0 (16 in Q12.4).
  task automatic test_identity_cases();
    foreach (next_matrix[i]) next_matrix[i] = 32'h0;
    set_entry(0, 0, 4096);
    set_entry(1, 1, 4096);
    set_entry(2, 2, 4096);
    set_entry(3, 3, 4096);
    load_matrix();
    // Points inside, on each face, and at the extremes of the range.
    send_req(point_req(0, 0, 0));
    send_req(point_req(16, 0, 0));
    send_req(point_req(-16, 0, 0));
    send_req(point_req(0, 16, 0));
    send_req(point_req(0, -16, 0));
    send_req(point_req(0, 0, 16));
    send_req(point_req(0, 0, -16));
    send_req(point_req(32767, 32767, 32767));
    send_req(point_req(-32768, -32768, -32768));
    // Boxes inside, straddling, outside, touching a face, inverted, huge, flat.
    send_req(box_req(-8, -8, -8, 8, 8, 8));
    send_req(box_req(-8, -8, -8, 40, 8, 8));
    send_req(box_req(32, -8, -8, 64, 8, 8));
    send_req(box_req(16, -8, -8, 32, 8, 8));
    send_req(box_req(8, 8, 8, -8, -8, -8));
    send_req(box_req(-32768, -32768, -32768, 32767, 32767, 32767));
    send_req(box_req(0, 0, 0, 0, 0, 0));
    send_req(box_req(-8, -8, -64, 8, 8, -32));
    send_req(box_req(32767, 32767, 32767, -32768, -32768, -32768));
  endtask

  // Register patterns of all zeros, all ones and the entry extremes; the extremes give the widest plane coefficients.
  task automatic test_extreme_matrices();
    for (int s = 0; s < 5; s++) begin
      case (s)
        0: foreach (next_matrix[i]) next_matrix[i] = 32'h0000_0000;
        1: foreach (next_matrix[i]) next_matrix[i] = 32'h8000_8000;
        2: foreach (next_matrix[i]) next_matrix[i] = 32'h7FFF_7FFF;
        3: foreach (next_matrix[i]) next_matrix[i] = 32'hFFFF_FFFF;
        default: foreach (next_matrix[i]) next_matrix[i] = 32'h8000_8000;
      endcase
      if (s >= 3) begin
        next_matrix[REG_COL3_ROWS01] = 32'h7FFF_7FFF;
        next_matrix[REG_COL3_ROWS23] = 32'h7FFF_7FFF;
      end
      load_matrix();
      for (int n = 0; n < 8; n++) send_req(random_request(($urandom_range(0, 1) == 1) ? 600
                                                                                      : 16000));
    end
  endtask

  // Random matrices and request streams, with single-register updates,
  // ignored writes and full pauses between and inside phases.
  task automatic test_random_frustums();
    int span;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      steady = ($urandom_range(0, 3) == 0);
      pick_random_matrix();
      load_matrix();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 2))
          0: span = 64;
          1: span = 600;
          default: span = 4000;
        endcase
        send_req(random_request(span));
        if (n == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 1) begin
          drain_results();
          if ($urandom_range(0, 1) == 1)
            write_matrix_reg(CFG_INDEX_W'($urandom_range(0, REG_COUNT - 1)), $urandom);
          else
            write_matrix_reg(CFG_INDEX_W'($urandom_range(REG_COUNT, (1 << CFG_INDEX_W) - 1)),
                             $urandom);
          cfg_valid <= 1'b0;
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    point_count = 0;
    box_count = 0;
    vis_seen = '{0, 0, 0};
    cfg_writes = 0;
    settings_loaded = 0;
    burst_left = 0;
    steady = 1'b0;
    mat_regs = '{32'h0000_1000, 32'h0, 32'h1000_0000, 32'h0,
                 32'h0, 32'h0000_1000, 32'h0, 32'h1000_0000};
    foreach (plane_coef[p]) begin
      plane_neg[p] = '0;
      foreach (plane_coef[p][r]) plane_coef[p][r] = 0;
    end
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_unloaded_planes();
    test_identity_cases();
    test_extreme_matrices();
    test_random_frustums();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d point tests and %0d box tests (outside %0d, partial %0d, inside %0d).",
             point_count, box_count, vis_seen[0], vis_seen[1], vis_seen[2]);
    $display("Loaded %0d matrices over %0d register writes; %0d mismatches.",
             settings_loaded, cfg_writes, mismatches);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
